/* hdl/assert_macros.svh */
// assertion macros used by the rtl top level
// no dependencies; included by the top level, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication property checked on every rising edge, masked in reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hdl/i2cee_pkg.sv */
// types, phase codes and constants of the i2c eeprom byte master
// no dependencies; imported by i2cee_step and the top level
`default_nettype none

package i2cee_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CYCLE_TICKS = 2'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  TPD_RESET = 8'd2;
  localparam logic [15:0] WCT_RESET = 16'd1000;

  // actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  // status / byte stage codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DEV_NACK = 3'd1;
  localparam logic [2:0] ST_AHI_NACK = 3'd2;
  localparam logic [2:0] ST_ALO_NACK = 3'd3;
  localparam logic [2:0] ST_RST_NACK = 3'd4;
  localparam logic [2:0] ST_DAT_NACK = 3'd5;

  // bus sequencer phases
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_A   = 5'd1;
  localparam logic [4:0] PH_START_B   = 5'd2;
  localparam logic [4:0] PH_WBIT_LOW  = 5'd3;
  localparam logic [4:0] PH_WBIT_HIGH = 5'd4;
  localparam logic [4:0] PH_ACK_LOW   = 5'd5;
  localparam logic [4:0] PH_ACK_HIGH  = 5'd6;
  localparam logic [4:0] PH_RESTART_A = 5'd7;
  localparam logic [4:0] PH_RESTART_B = 5'd8;
  localparam logic [4:0] PH_RBIT_LOW  = 5'd9;
  localparam logic [4:0] PH_RBIT_HIGH = 5'd10;
  localparam logic [4:0] PH_NACK_LOW  = 5'd11;
  localparam logic [4:0] PH_NACK_HIGH = 5'd12;
  localparam logic [4:0] PH_STOP_A    = 5'd13;
  localparam logic [4:0] PH_STOP_B    = 5'd14;
  localparam logic [4:0] PH_STOP_C    = 5'd15;
  localparam logic [4:0] PH_WAIT      = 5'd16;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  device_address;
    logic [15:0] memory_address;
    logic [7:0]  write_data;
    logic        sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic [2:0] status;
  } out_t;

  typedef struct packed {
    logic [4:0]  phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_byte;
    logic [15:0] tick_count;
    logic [6:0]  latched_device;
    logic [15:0] latched_address;
    logic [7:0]  latched_data;
    logic        is_read;
    logic [2:0]  last_status;
    logic        scl;
    logic        sda;
    logic [2:0]  byte_stage;
  } st_t;

  typedef struct packed {
    logic [7:0]  ticks_per_delay;
    logic [15:0] write_cycle_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/i2cee_step.sv */
// next-state and result logic for one tick of the bus sequencer
// depends on i2cee_pkg
`default_nettype none

module i2cee_step import i2cee_pkg::*; (
  input  wire st_t  cur,
  input  wire in_t  item,
  input  wire cfg_t cfg,
  output st_t       nxt,
  output out_t      res
);

  function automatic st_t go_ph(st_t s, logic [4:0] ph, logic scl, logic sda);
    s.phase      = ph;
    s.scl        = scl;
    s.sda        = sda;
    s.tick_count = '0;
    return s;
  endfunction

  function automatic st_t send_byte(st_t s, logic [2:0] stage, logic [7:0] v);
    s.byte_stage = stage;
    s.shift_byte = v;
    s.bit_count  = '0;
    return go_ph(s, PH_WBIT_LOW, 1'b0, v[7]);
  endfunction

  logic       done;
  logic       unit_end;
  logic [7:0] unit_len;

  always_comb begin
    nxt      = cur;
    done     = 1'b0;
    unit_end = 1'b0;
    unit_len = (cfg.ticks_per_delay == 8'd0) ? 8'd1 : cfg.ticks_per_delay;

    if (cur.phase == PH_IDLE) begin
      if (item.action == ACT_READ || item.action == ACT_WRITE) begin
        nxt.latched_device  = item.device_address;
        nxt.latched_address = item.memory_address;
        nxt.latched_data    = item.write_data;
        nxt.is_read         = (item.action == ACT_READ);
        nxt.last_status     = ST_OK;
        nxt.byte_stage      = ST_DEV_NACK;
        nxt.shift_byte      = {item.device_address, 1'b0};
        nxt = go_ph(nxt, PH_START_A, 1'b1, 1'b0);
      end
    end else if (cur.phase == PH_WAIT) begin
      nxt.tick_count = cur.tick_count + 16'd1;
      if (nxt.tick_count >= cfg.write_cycle_ticks) begin
        nxt  = go_ph(nxt, PH_IDLE, 1'b1, 1'b1);
        done = 1'b1;
      end
    end else begin
      nxt.tick_count = cur.tick_count + 16'd1;
      unit_end = (nxt.tick_count >= {8'd0, unit_len});
    end

    if (unit_end) begin
      case (cur.phase)
        PH_START_A:   nxt = go_ph(nxt, PH_START_B, 1'b0, 1'b0);
        PH_START_B:   nxt = send_byte(nxt, cur.byte_stage, cur.shift_byte);
        PH_WBIT_LOW:  nxt = go_ph(nxt, PH_WBIT_HIGH, 1'b1, cur.sda);
        PH_WBIT_HIGH: begin
          nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
          nxt.bit_count  = cur.bit_count + 4'd1;
          if (nxt.bit_count >= BITS_PER_BYTE) begin
            nxt = go_ph(nxt, PH_ACK_LOW, 1'b0, 1'b1);
          end else begin
            nxt = go_ph(nxt, PH_WBIT_LOW, 1'b0, cur.shift_byte[6]);
          end
        end
        PH_ACK_LOW:   nxt = go_ph(nxt, PH_ACK_HIGH, 1'b1, 1'b1);
        PH_ACK_HIGH: begin
          if (item.sda_in) begin
            nxt.last_status = cur.byte_stage;
            nxt = go_ph(nxt, PH_STOP_A, 1'b0, 1'b0);
          end else begin
            case (cur.byte_stage)
              ST_DEV_NACK: nxt = send_byte(nxt, ST_AHI_NACK, cur.latched_address[15:8]);
              ST_AHI_NACK: nxt = send_byte(nxt, ST_ALO_NACK, cur.latched_address[7:0]);
              ST_ALO_NACK: begin
                if (cur.is_read) begin
                  nxt.byte_stage = ST_RST_NACK;
                  nxt = go_ph(nxt, PH_RESTART_A, 1'b0, 1'b1);
                end else begin
                  nxt = send_byte(nxt, ST_DAT_NACK, cur.latched_data);
                end
              end
              ST_RST_NACK: begin
                nxt.shift_byte = '0;
                nxt.bit_count  = '0;
                nxt = go_ph(nxt, PH_RBIT_LOW, 1'b0, 1'b1);
              end
              default:     nxt = go_ph(nxt, PH_STOP_A, 1'b0, 1'b0);
            endcase
          end
        end
        PH_RESTART_A: nxt = go_ph(nxt, PH_RESTART_B, 1'b1, 1'b1);
        PH_RESTART_B: begin
          nxt.shift_byte = {cur.latched_device, 1'b1};
          nxt = go_ph(nxt, PH_START_A, 1'b1, 1'b0);
        end
        PH_RBIT_LOW:  nxt = go_ph(nxt, PH_RBIT_HIGH, 1'b1, 1'b1);
        PH_RBIT_HIGH: begin
          nxt.shift_byte = {cur.shift_byte[6:0], item.sda_in};
          nxt.bit_count  = cur.bit_count + 4'd1;
          if (nxt.bit_count >= BITS_PER_BYTE) begin
            nxt = go_ph(nxt, PH_NACK_LOW, 1'b0, 1'b1);
          end else begin
            nxt = go_ph(nxt, PH_RBIT_LOW, 1'b0, 1'b1);
          end
        end
        PH_NACK_LOW:  nxt = go_ph(nxt, PH_NACK_HIGH, 1'b1, 1'b1);
        PH_NACK_HIGH: nxt = go_ph(nxt, PH_STOP_A, 1'b0, 1'b0);
        PH_STOP_A:    nxt = go_ph(nxt, PH_STOP_B, 1'b1, 1'b0);
        PH_STOP_B:    nxt = go_ph(nxt, PH_STOP_C, 1'b1, 1'b1);
        PH_STOP_C: begin
          if (!cur.is_read && cur.last_status == ST_OK &&
              cfg.write_cycle_ticks != 16'd0) begin
            nxt = go_ph(nxt, PH_WAIT, 1'b1, 1'b1);
          end else begin
            nxt  = go_ph(nxt, PH_IDLE, 1'b1, 1'b1);
            done = 1'b1;
          end
        end
        default:      nxt = go_ph(nxt, PH_IDLE, 1'b1, 1'b1);
      endcase
    end

    res.scl_level = nxt.scl;
    res.sda_level = nxt.sda;
    res.busy_res  = (nxt.phase != PH_IDLE);
    res.done_res  = done;
    res.read_byte = (done && nxt.is_read && nxt.last_status == ST_OK) ?
                    nxt.shift_byte : 8'd0;
    res.status    = nxt.last_status;
  end

endmodule

`default_nettype wire

/* hdl/i2c_eeprom_byte_master.sv */
// top level of the i2c eeprom byte master: input stage, state, result register
// depends on i2cee_pkg, i2cee_step and assert_macros.svh
`default_nettype none

// channel   dir  handshake              payload
// in_       in   in_valid / in_ready    in_data   (in_t: action .. sda_in)
// out_      out  out_valid / out_ready  out_data  (out_t: scl_level .. status)
// cfg_      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item is one bus tick; one result item comes out per item
// an item is held in the input stage, then one pass of the step logic
// updates the sequencer state and loads the result register; one item per
// cycle sustained while the result is not stalled, set by the state update
// reset loads phase idle, scl/sda released and the config reset values
// a stalled result holds; the input stage still takes one more item behind it

module i2c_eeprom_byte_master import i2cee_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire in_t             in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output out_t                 out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  // input stage
  logic s1_valid_r, s1_valid_nxt;
  in_t  s1_data_r;
  logic s1_adv;

  // sequencer state and config
  st_t  st_r, st_nxt;
  cfg_t cfg_r, cfg_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  out_t step_res;

  // terms used by the checks
  logic chk_done;
  logic chk_rbyte;
  logic s1_stall;

  // stage 1 moves on when the result register is free or being emptied
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_TICKS_PER_DELAY:   cfg_nxt.ticks_per_delay   = cfg_data[7:0];
        CFG_WRITE_CYCLE_TICKS: cfg_nxt.write_cycle_ticks = cfg_data;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  i2cee_step u_step (
    .cur  (st_r),
    .item (s1_data_r),
    .cfg  (cfg_r),
    .nxt  (st_nxt),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r       <= '{ticks_per_delay: TPD_RESET, write_cycle_ticks: WCT_RESET};
      st_r        <= '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  assign chk_done  = out_valid_r && out_data_r.done_res;
  assign chk_rbyte = out_valid_r && (out_data_r.read_byte != 8'd0);
  assign s1_stall  = s1_valid_r && !s1_adv;

  `ASSERT_NEVER(a_done_not_busy, clk, rst_n, chk_done && out_data_r.busy_res)
  `ASSERT_NEVER(a_rbyte_only_done, clk, rst_n, chk_rbyte && !out_data_r.done_res)
  `ASSERT_CLK(a_idle_released, clk, rst_n, st_r.phase == PH_IDLE |-> st_r.scl && st_r.sda)
  `ASSERT_CLK(a_s1_holds, clk, rst_n, s1_stall |=> s1_valid_r && $stable({s1_data_r, st_r}))

endmodule

`default_nettype wire
